>>> sv/bba_pkg.sv
// shared types, codes and helpers of the bitmap bucket allocator
`default_nettype none
package bba_pkg;

  // default bucket count and the count width that covers the whole parameter range
  localparam int unsigned MaxBucketsDef = 256;
  localparam int unsigned CntW = 13;

  // request codes
  localparam logic [1:0] OpAlloc  = 2'd0;
  localparam logic [1:0] OpFree   = 2'd1;
  localparam logic [1:0] OpResize = 2'd2;

  // result status codes
  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StMoved   = 2'd1;
  localparam logic [1:0] StFailed  = 2'd2;
  localparam logic [1:0] StIgnored = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CfgBase   = 2'd0;
  localparam logic [1:0] CfgBucket = 2'd1;
  localparam logic [1:0] CfgAlign  = 2'd2;
  localparam logic [1:0] CfgCount  = 2'd3;

  typedef enum logic [1:0] {
    KindAlloc,
    KindFree,
    KindResize,
    KindIgnore
  } bba_kind_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [23:0] request_bytes;
    logic [7:0]  align_bytes;
    logic [7:0]  held_start;
    logic [23:0] held_bytes;
    logic        held_valid;
  } bba_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  first_bucket;
    logic [31:0] block_address;
    logic [23:0] usable_bytes;
    logic [8:0]  used_count;
  } bba_res_t;

  typedef struct packed {
    logic [31:0] base_address;
    logic [16:0] bucket_bytes;
    logic [7:0]  bucket_alignment;
    logic [8:0]  buckets_in_use;
  } bba_cfg_t;

  // classified word handed from the front to the back
  typedef struct packed {
    bba_kind_e       kind;
    logic            shrink;
    logic [7:0]      pad;
    logic [7:0]      align;
    logic [7:0]      bid;
    logic [CntW-1:0] held;
    logic [CntW-1:0] blocks;
  } bba_work_t;

  // bucket size with zero and oversize values folded into range
  function automatic logic [16:0] eff_bucket(input logic [16:0] raw);
    logic [16:0] v;
    v = raw;
    if (raw == 17'd0) begin
      v = 17'd1;
    end else if (raw > 17'h10000) begin
      v = 17'h10000;
    end
    return v;
  endfunction

  function automatic logic [CntW-1:0] cmin(input logic [CntW-1:0] a, input logic [CntW-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage
`default_nettype wire

>>> sv/bba_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module bba_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned VW = 17
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      quot_o,
  output logic [VW-1:0]      rem_o
);
  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] q_q;
  logic [VW-1:0] r_q, d_q;
  logic [VW:0]   trial, diff;
  logic          ge;

  // one trial subtraction
  always_comb begin
    trial = {r_q, q_q[DW-1]};
    diff  = trial - {1'b0, d_q};
    ge    = trial >= {1'b0, d_q};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      r_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
      q_q <= {q_q[DW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;
endmodule
`default_nettype wire

>>> sv/bba_fifo.sv
// two-entry word queue
`default_nettype none
module bba_fifo #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic [W-1:0]      data_o,
  output logic              empty_o
);
  logic [W-1:0] buf_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = buf_q[rp_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wp_q] <= data_i;
  end
endmodule
`default_nettype wire

>>> sv/bba_front.sv
// front end: takes requests, works out padding and bucket counts, classifies
`default_nettype none
module bba_front import bba_pkg::*; #(
  parameter int unsigned MAX_BUCKETS = MaxBucketsDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  output logic           full_o,
  input  wire bba_req_t  req_i,
  input  wire bba_cfg_t  cfg_i,
  input  wire logic      init_done_i,
  output bba_work_t      work_o,
  output logic           work_push_o,
  input  wire logic      work_full_i
);
  localparam logic [CntW-1:0] MaxC = CntW'(MAX_BUCKETS);

  typedef enum logic [3:0] {
    F_IDLE, F_PAD, F_PADW, F_SIZE, F_SIZEW, F_HELD, F_HELDW, F_CLASS, F_PUSH
  } fst_e;

  fst_e            st_q;
  bba_req_t        req_q;
  logic [7:0]      pad_q;
  logic [24:0]     size_q;
  logic [CntW-1:0] blocks_q, held_q;
  bba_work_t       work_q;

  logic [16:0]     bb;
  logic [CntW-1:0] n;
  logic [24:0]     size_w;
  logic            div_start, div_done;
  logic [24:0]     div_dend, div_quot;
  logic [16:0]     div_dsor, div_rem;
  logic            valid_w;
  logic            trim_w;

  function automatic logic [CntW-1:0] clampq(input logic [24:0] q, input logic [CntW-1:0] lim);
    return (q > 25'(lim)) ? lim : q[CntW-1:0];
  endfunction

  // effective configuration
  always_comb begin
    bb     = eff_bucket(cfg_i.bucket_bytes);
    n      = (CntW'(cfg_i.buckets_in_use) > MaxC) ? MaxC : CntW'(cfg_i.buckets_in_use);
    size_w = 25'(req_q.request_bytes) + 25'(pad_q);
    valid_w = req_q.held_valid && (req_q.held_bytes != 24'd0)
              && (CntW'(req_q.held_start) < n);
    // only an in-place shrink of an owned block caps the count at what it holds
    trim_w = valid_w && (req_q.op == OpResize) && (size_q < 25'(req_q.held_bytes))
             && (held_q < blocks_q);
  end

  // divider operands per step
  always_comb begin
    div_start = 1'b0;
    div_dend  = '0;
    div_dsor  = '0;
    case (st_q)
      F_PAD: begin
        div_dend  = 25'(cfg_i.bucket_alignment);
        div_dsor  = 17'(req_q.align_bytes);
        div_start = (req_q.align_bytes != 8'd0)
                    && (req_q.align_bytes <= cfg_i.bucket_alignment);
      end
      F_SIZE: begin
        div_dend  = size_w + 25'(bb) - 25'd1;
        div_dsor  = bb;
        div_start = size_w > 25'(bb);
      end
      F_HELD: begin
        div_dend  = 25'(req_q.held_bytes);
        div_dsor  = bb;
        div_start = req_q.held_bytes > 24'(bb);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  bba_div #(.DW(25), .VW(17)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dend),
    .divisor_i  (div_dsor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= F_IDLE;
      req_q    <= '0;
      pad_q    <= '0;
      size_q   <= '0;
      blocks_q <= '0;
      held_q   <= '0;
      work_q   <= '0;
    end else begin
      case (st_q)
        F_IDLE: begin
          if (push_i && !full_o) begin
            req_q <= req_i;
            st_q  <= F_PAD;
          end
        end
        F_PAD: begin
          if (req_q.align_bytes == 8'd0) begin
            pad_q <= 8'd0;
            st_q  <= F_SIZE;
          end else if (req_q.align_bytes > cfg_i.bucket_alignment) begin
            pad_q <= req_q.align_bytes;
            st_q  <= F_SIZE;
          end else begin
            st_q <= F_PADW;
          end
        end
        F_PADW: begin
          if (div_done) begin
            pad_q <= (div_rem != 17'd0) ? req_q.align_bytes : 8'd0;
            st_q  <= F_SIZE;
          end
        end
        F_SIZE: begin
          size_q <= size_w;
          if (size_w > 25'(bb)) begin
            st_q <= F_SIZEW;
          end else begin
            blocks_q <= CntW'(1);
            st_q     <= F_HELD;
          end
        end
        F_SIZEW: begin
          if (div_done) begin
            blocks_q <= clampq(div_quot, MaxC + CntW'(1));
            st_q     <= F_HELD;
          end
        end
        F_HELD: begin
          if (req_q.held_bytes > 24'(bb)) begin
            st_q <= F_HELDW;
          end else begin
            held_q <= CntW'(1);
            st_q   <= F_CLASS;
          end
        end
        F_HELDW: begin
          if (div_done) begin
            held_q <= clampq(div_quot, MaxC);
            st_q   <= F_CLASS;
          end
        end
        F_CLASS: begin
          work_q.pad    <= pad_q;
          work_q.align  <= req_q.align_bytes;
          work_q.bid    <= req_q.held_start;
          work_q.held   <= held_q;
          work_q.shrink <= size_q < 25'(req_q.held_bytes);
          // a shrink never keeps more than it holds
          work_q.blocks <= trim_w ? held_q : blocks_q;
          case (req_q.op)
            OpAlloc:  work_q.kind <= KindAlloc;
            OpFree:   work_q.kind <= valid_w ? KindFree : KindIgnore;
            OpResize: work_q.kind <= valid_w ? KindResize : KindAlloc;
            default:  work_q.kind <= KindIgnore;
          endcase
          st_q <= F_PUSH;
        end
        F_PUSH: begin
          if (!work_full_i) st_q <= F_IDLE;
        end
        default: begin
          st_q <= F_IDLE;
        end
      endcase
    end
  end

  assign full_o      = (st_q != F_IDLE) || !init_done_i;
  assign work_o      = work_q;
  assign work_push_o = (st_q == F_PUSH) && !work_full_i;
endmodule
`default_nettype wire

>>> sv/bba_back.sv
// back end: used map memory, first-fit scan, mark and clear walks, result build
`default_nettype none
module bba_back import bba_pkg::*; #(
  parameter int unsigned MAX_BUCKETS = MaxBucketsDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire bba_cfg_t  cfg_i,
  input  wire bba_work_t work_i,
  input  wire logic      work_empty_i,
  output logic           work_pop_o,
  output bba_res_t       res_o,
  output logic           res_push_o,
  input  wire logic      res_full_i,
  output logic           init_done_o
);
  localparam int unsigned IdxW = $clog2(MAX_BUCKETS);
  localparam logic [CntW-1:0] MaxC = CntW'(MAX_BUCKETS);

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_WALK, B_SCAN, B_MUL, B_ADDR, B_MODW, B_FIN, B_OUT
  } bst_e;

  typedef enum logic [1:0] {
    AF_MUL, AF_OUT, AF_FREEOLD
  } after_e;

  bst_e            st_q;
  after_e          after_q;
  bba_work_t       work_q;
  logic [CntW-1:0] ptr_q, end_q, paddr_q, run_q, start_q, cnt_q, total_q;
  logic            pend_q, wval_q, brk_q, moved_q, fitm_q;
  logic [7:0]      mod_q, adj_q;
  logic [1:0]      status_q;
  logic [29:0]     a0p_q, tot_q;
  logic [31:0]     a0_q;
  logic [7:0]      first_q;
  logic [31:0]     addr_q;
  logic [23:0]     usable_q;

  logic            mem_q [MAX_BUCKETS];
  logic            mem_rd_q;
  logic            mem_we, mem_wd;
  logic [IdxW-1:0] mem_wa, mem_ra;

  logic [16:0]     bb;
  logic [CntW-1:0] n, run_inc, wbid, hbid;
  logic            sc_hit, sc_stop;
  logic [31:0]     a0_w;
  logic            div_start, div_done;
  logic [16:0]     div_rem;
  logic [7:0]      sub_w;
  logic [29:0]     use_w;

  // effective configuration and helpers
  always_comb begin
    bb      = eff_bucket(cfg_i.bucket_bytes);
    n       = (CntW'(cfg_i.buckets_in_use) > MaxC) ? MaxC : CntW'(cfg_i.buckets_in_use);
    run_inc = run_q + CntW'(1);
    wbid    = CntW'(work_i.bid);
    hbid    = CntW'(work_q.bid);
    sc_hit  = pend_q && !mem_rd_q && (run_inc == work_q.blocks);
    sc_stop = (pend_q && mem_rd_q && brk_q) || (!pend_q && (ptr_q >= end_q));
    a0_w    = cfg_i.base_address + 32'(a0p_q);
    sub_w   = fitm_q ? adj_q : mod_q;
    use_w   = (tot_q > 30'(sub_w)) ? tot_q - 30'(sub_w) : 30'd0;
  end

  // map memory ports
  always_comb begin
    mem_ra = ptr_q[IdxW-1:0];
    mem_we = 1'b0;
    mem_wa = paddr_q[IdxW-1:0];
    mem_wd = wval_q;
    if (st_q == B_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = ptr_q[IdxW-1:0];
      mem_wd = 1'b0;
    end else if (st_q == B_WALK) begin
      mem_we = pend_q && (mem_rd_q != wval_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    mem_rd_q <= mem_q[mem_ra];
  end

  // address alignment remainder
  assign div_start = (st_q == B_ADDR) && (mod_q != 8'd0);

  bba_div #(.DW(32), .VW(17)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a0_w),
    .divisor_i  (17'(mod_q)),
    .done_o     (div_done),
    .quot_o     (),
    .rem_o      (div_rem)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= B_CLEAR;
      after_q  <= AF_OUT;
      work_q   <= '0;
      ptr_q    <= '0;
      end_q    <= '0;
      paddr_q  <= '0;
      run_q    <= '0;
      start_q  <= '0;
      cnt_q    <= '0;
      total_q  <= '0;
      pend_q   <= 1'b0;
      wval_q   <= 1'b0;
      brk_q    <= 1'b0;
      moved_q  <= 1'b0;
      fitm_q   <= 1'b0;
      mod_q    <= '0;
      adj_q    <= '0;
      status_q <= StIgnored;
      a0p_q    <= '0;
      tot_q    <= '0;
      a0_q     <= '0;
      first_q  <= '0;
      addr_q   <= '0;
      usable_q <= '0;
    end else begin
      case (st_q)
        // clearing pass over the map after reset
        B_CLEAR: begin
          ptr_q <= ptr_q + CntW'(1);
          if (ptr_q == MaxC - CntW'(1)) st_q <= B_IDLE;
        end
        // take the next classified word
        B_IDLE: begin
          if (!work_empty_i) begin
            work_q   <= work_i;
            first_q  <= '0;
            addr_q   <= '0;
            usable_q <= '0;
            moved_q  <= 1'b0;
            pend_q   <= 1'b0;
            start_q  <= wbid;
            cnt_q    <= work_i.blocks;
            mod_q    <= work_i.align;
            fitm_q   <= 1'b1;
            status_q <= StDone;
            case (work_i.kind)
              KindIgnore: begin
                status_q <= StIgnored;
                st_q     <= B_OUT;
              end
              KindFree: begin
                ptr_q   <= wbid;
                end_q   <= cmin(wbid + work_i.held, n);
                wval_q  <= 1'b0;
                after_q <= AF_OUT;
                st_q    <= B_WALK;
              end
              KindAlloc: begin
                ptr_q <= '0;
                end_q <= n;
                run_q <= '0;
                brk_q <= 1'b0;
                st_q  <= B_SCAN;
              end
              default: begin
                if (work_i.shrink) begin
                  // release the tail buckets
                  ptr_q   <= wbid + work_i.blocks;
                  end_q   <= cmin(wbid + work_i.held, n);
                  wval_q  <= 1'b0;
                  after_q <= AF_MUL;
                  st_q    <= B_WALK;
                end else if (work_i.held >= work_i.blocks) begin
                  ptr_q   <= wbid;
                  end_q   <= cmin(wbid + work_i.blocks, n);
                  wval_q  <= 1'b1;
                  after_q <= AF_MUL;
                  st_q    <= B_WALK;
                end else begin
                  // try to grow into the following free buckets
                  ptr_q <= wbid + work_i.held;
                  end_q <= n;
                  run_q <= work_i.held;
                  brk_q <= 1'b1;
                  st_q  <= B_SCAN;
                end
              end
            endcase
          end
        end
        // read-modify-write walk over a bucket range
        B_WALK: begin
          if (pend_q && (mem_rd_q != wval_q)) begin
            total_q <= wval_q ? total_q + CntW'(1) : total_q - CntW'(1);
          end
          if (ptr_q < end_q) begin
            pend_q  <= 1'b1;
            paddr_q <= ptr_q;
            ptr_q   <= ptr_q + CntW'(1);
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              case (after_q)
                AF_MUL: st_q <= B_MUL;
                AF_FREEOLD: begin
                  ptr_q   <= hbid;
                  end_q   <= cmin(hbid + work_q.held, n);
                  wval_q  <= 1'b0;
                  after_q <= AF_MUL;
                end
                default: st_q <= B_OUT;
              endcase
            end
          end
        end
        // first-fit or grow scan
        B_SCAN: begin
          if (sc_hit) begin
            pend_q <= 1'b0;
            wval_q <= 1'b1;
            st_q   <= B_WALK;
            if (brk_q) begin
              ptr_q   <= hbid;
              end_q   <= cmin(hbid + work_q.blocks, n);
              after_q <= AF_MUL;
            end else begin
              ptr_q    <= paddr_q + CntW'(1) - work_q.blocks;
              end_q    <= paddr_q + CntW'(1);
              start_q  <= paddr_q + CntW'(1) - work_q.blocks;
              mod_q    <= work_q.pad;
              fitm_q   <= 1'b0;
              status_q <= moved_q ? StMoved : StDone;
              after_q  <= moved_q ? AF_FREEOLD : AF_MUL;
            end
          end else if (sc_stop) begin
            pend_q <= 1'b0;
            if (brk_q) begin
              // no room in place: allocate anew
              ptr_q   <= '0;
              end_q   <= n;
              run_q   <= '0;
              brk_q   <= 1'b0;
              moved_q <= 1'b1;
            end else begin
              status_q <= StFailed;
              st_q     <= B_OUT;
            end
          end else begin
            if (pend_q) run_q <= mem_rd_q ? '0 : run_inc;
            if (ptr_q < end_q) begin
              pend_q  <= 1'b1;
              paddr_q <= ptr_q;
              ptr_q   <= ptr_q + CntW'(1);
            end else begin
              pend_q <= 1'b0;
            end
          end
        end
        // bucket offset and block size products
        B_MUL: begin
          a0p_q <= bb * start_q;
          tot_q <= bb * cnt_q;
          st_q  <= B_ADDR;
        end
        B_ADDR: begin
          a0_q <= a0_w;
          if (mod_q != 8'd0) begin
            st_q <= B_MODW;
          end else begin
            adj_q <= 8'd0;
            st_q  <= B_FIN;
          end
        end
        B_MODW: begin
          if (div_done) begin
            adj_q <= (div_rem[7:0] != 8'd0) ? mod_q - div_rem[7:0] : 8'd0;
            st_q  <= B_FIN;
          end
        end
        // result fields
        B_FIN: begin
          first_q  <= start_q[7:0];
          addr_q   <= a0_q + 32'(adj_q);
          usable_q <= (use_w[29:24] != 6'd0) ? 24'hFFFFFF : use_w[23:0];
          st_q     <= B_OUT;
        end
        B_OUT: begin
          if (!res_full_i) st_q <= B_IDLE;
        end
        default: begin
          st_q <= B_IDLE;
        end
      endcase
    end
  end

  assign work_pop_o         = (st_q == B_IDLE) && !work_empty_i;
  assign res_push_o         = (st_q == B_OUT) && !res_full_i;
  assign init_done_o        = st_q != B_CLEAR;
  assign res_o.status       = status_q;
  assign res_o.first_bucket = first_q;
  assign res_o.block_address = addr_q;
  assign res_o.usable_bytes = usable_q;
  assign res_o.used_count   = total_q[8:0];
endmodule
`default_nettype wire

>>> sv/bitmap_bucket_allocator.sv
// top level of the bitmap bucket allocator
//
//   channel   signals                                  direction
//   request   push, full, req_i                         in
//   result    empty, pop, res_o                         out
//   config    cfg_valid_i, cfg_ready_o, cfg_index_i,    in
//             cfg_data_i
//
// One request at a time in the front: up to three divisions in its divider
// (alignment check, bucket count, held count). The back scans the map one
// bucket per cycle from its single read port, then walks the marked or released
// range one bucket per cycle, plus a remainder division for the aligned address.
// After reset a clearing pass over the map holds full high; config writes are
// taken at any time. A two-word queue parts front and back, and another holds
// finished results.
`default_nettype none
module bitmap_bucket_allocator import bba_pkg::*; #(
  parameter int unsigned MAX_BUCKETS = MaxBucketsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire bba_req_t    req_i,
  output logic             empty,
  input  wire logic        pop,
  output bba_res_t         res_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  bba_cfg_t  cfg_q;
  bba_work_t fwork, bwork;
  logic      fpush, mfull, mempty, bpop, rpush, rfull, init_done;
  bba_res_t  bres;
  logic [$bits(bba_work_t)-1:0] mid_out;
  logic [$bits(bba_res_t)-1:0]  res_out;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_address     <= 32'd0;
      cfg_q.bucket_bytes     <= 17'd64;
      cfg_q.bucket_alignment <= 8'd16;
      cfg_q.buckets_in_use   <= 9'd256;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgBase:   cfg_q.base_address     <= cfg_data_i;
        CfgBucket: cfg_q.bucket_bytes     <= cfg_data_i[16:0];
        CfgAlign:  cfg_q.bucket_alignment <= cfg_data_i[7:0];
        CfgCount:  cfg_q.buckets_in_use   <= cfg_data_i[8:0];
        default:   cfg_q.base_address     <= cfg_q.base_address;
      endcase
    end
  end

  bba_front #(.MAX_BUCKETS(MAX_BUCKETS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .req_i       (req_i),
    .cfg_i       (cfg_q),
    .init_done_i (init_done),
    .work_o      (fwork),
    .work_push_o (fpush),
    .work_full_i (mfull)
  );

  // queue between front and back
  bba_fifo #(.W($bits(bba_work_t))) u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fpush),
    .data_i  (fwork),
    .full_o  (mfull),
    .pop_i   (bpop),
    .data_o  (mid_out),
    .empty_o (mempty)
  );
  assign bwork = bba_work_t'(mid_out);

  bba_back #(.MAX_BUCKETS(MAX_BUCKETS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .work_i       (bwork),
    .work_empty_i (mempty),
    .work_pop_o   (bpop),
    .res_o        (bres),
    .res_push_o   (rpush),
    .res_full_i   (rfull),
    .init_done_o  (init_done)
  );

  // result queue
  bba_fifo #(.W($bits(bba_res_t))) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rpush),
    .data_i  (bres),
    .full_o  (rfull),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );
  assign res_o = bba_res_t'(res_out);
endmodule
`default_nettype wire

>>> dv/bba_checker.sv
// checker of the bitmap bucket allocator: watches all channels, predicts and compares
`timescale 1ns / 1ps
module bba_checker import bba_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  input  wire logic        full,
  input  wire bba_req_t    req_i,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire bba_res_t    res_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output int unsigned      checked_o
);

  localparam int unsigned NumBuckets = MaxBucketsDef;

  // predicted map and register copies
  bit          used_map [NumBuckets];
  int unsigned used_sum;
  logic [31:0] base_r;
  logic [16:0] bkt_r;
  logic [7:0]  aln_r;
  logic [8:0]  cnt_r;

  bba_res_t expected_q[$];

  assign pending_o = expected_q.size();

  function automatic longint unsigned bucket_size();
    if (bkt_r == 17'd0) return 1;
    if (bkt_r > 17'h10000) return 65536;
    return bkt_r;
  endfunction

  function automatic int unsigned managed();
    return (cnt_r > NumBuckets) ? NumBuckets : cnt_r;
  endfunction

  function automatic void mark(int unsigned idx, bit v);
    if (idx >= managed() || idx >= NumBuckets) return;
    if (used_map[idx] != v) begin
      used_map[idx] = v;
      if (v) used_sum++;
      else if (used_sum > 0) used_sum--;
    end
  endfunction

  function automatic logic [31:0] align_gap(logic [31:0] addr, int unsigned align);
    logic [31:0] rem;
    if (align == 0) return 0;
    rem = addr % align;
    return (rem != 0) ? align - rem : 32'd0;
  endfunction

  function automatic bit pad_needed(int unsigned align);
    return align > 0 && (align > aln_r || (aln_r % align) != 0);
  endfunction

  function automatic logic [23:0] sat24(longint unsigned v);
    return (v > 64'hFFFFFF) ? 24'hFFFFFF : v[23:0];
  endfunction

  function automatic longint unsigned span(longint unsigned size, longint unsigned bb);
    if (size <= bb) return 1;
    return (size + bb - 1) / bb;
  endfunction

  function automatic int unsigned held_span(longint unsigned hb, longint unsigned bb);
    longint unsigned c;
    c = (hb <= bb) ? 1 : hb / bb;
    return (c > NumBuckets) ? NumBuckets : c;
  endfunction

  // first fit over the map
  function automatic bit first_fit(longint unsigned req, int unsigned align,
                                   inout bba_res_t r);
    longint unsigned bb, goal, run, start, pad;
    int unsigned     n;
    logic [31:0]     a0;
    bb = bucket_size();
    n = managed();
    pad = pad_needed(align) ? align : 0;
    goal = span(req + pad, bb);
    run = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (used_map[i]) begin
        run = 0;
      end else begin
        run++;
        if (run == goal) begin
          start = i + 1 - goal;
          for (longint unsigned k = start; k <= i; k++) mark(k, 1'b1);
          a0 = base_r + 32'(bb * start);
          r.status = StDone;
          r.first_bucket = start[7:0];
          r.block_address = a0 + align_gap(a0, pad);
          r.usable_bytes = sat24(bb * goal - pad);
          return 1'b1;
        end
      end
    end
    r.status = StFailed;
    return 1'b0;
  endfunction

  function automatic void release_run(int unsigned start, int unsigned cnt);
    for (int unsigned k = 0; k < cnt; k++) mark(start + k, 1'b0);
  endfunction

  // shrink, grow in place or move
  function automatic void resize_block(longint unsigned req, int unsigned align,
                                       int unsigned bid, longint unsigned hb,
                                       inout bba_res_t r);
    longint unsigned bb, size, keep, chain, blocks, total;
    int unsigned     n, held;
    logic [31:0]     a0, gap;
    bit              fit;
    bb = bucket_size();
    n = managed();
    held = held_span(hb, bb);
    size = req + (pad_needed(align) ? align : 0);
    a0 = base_r + 32'(bb * bid);
    gap = align_gap(a0, align);
    fit = 1'b0;
    if (size < hb) begin
      keep = span(size, bb);
      if (keep > held) keep = held;
      for (int unsigned k = keep; k < held; k++) mark(bid + k, 1'b0);
      blocks = keep;
      fit = 1'b1;
    end else begin
      chain = held;
      blocks = span(size, bb);
      if (chain >= blocks) begin
        fit = 1'b1;
      end else begin
        for (int unsigned i = bid + held; i < n; i++) begin
          if (used_map[i]) break;
          chain++;
          if (chain == blocks) begin
            fit = 1'b1;
            break;
          end
        end
      end
      if (fit) for (longint unsigned k = 0; k < blocks; k++) mark(bid + k, 1'b1);
    end
    if (fit) begin
      total = bb * blocks;
      r.status = StDone;
      r.first_bucket = bid[7:0];
      r.block_address = a0 + gap;
      r.usable_bytes = sat24(total > gap ? total - gap : 0);
      return;
    end
    if (first_fit(req, align, r)) begin
      release_run(bid, held);
      r.status = StMoved;
    end
  endfunction

  function automatic bba_res_t predict_result(bba_req_t q);
    bba_res_t r;
    bit       owned;
    owned = q.held_valid && q.held_bytes != 0 && q.held_start < managed();
    r = '0;
    r.status = StIgnored;
    case (q.op)
      OpAlloc: void'(first_fit(q.request_bytes, q.align_bytes, r));
      OpFree: begin
        if (owned) begin
          release_run(q.held_start, held_span(q.held_bytes, bucket_size()));
          r.status = StDone;
        end
      end
      OpResize: begin
        if (owned) resize_block(q.request_bytes, q.align_bytes, q.held_start,
                                q.held_bytes, r);
        else void'(first_fit(q.request_bytes, q.align_bytes, r));
      end
      default: ;
    endcase
    if (r.status == StFailed || r.status == StIgnored) begin
      r.first_bucket = '0;
      r.block_address = '0;
      r.usable_bytes = '0;
    end
    r.used_count = used_sum[8:0];
    return r;
  endfunction

  // monitor all three channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    bba_res_t e;
    if (!rst_ni) begin
      foreach (used_map[i]) used_map[i] = 1'b0;
      used_sum = 0;
      base_r = '0;
      bkt_r = 17'd64;
      aln_r = 8'd16;
      cnt_r = 9'd256;
      expected_q.delete();
      fail_count_o = 0;
      checked_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgBase:   base_r = cfg_data_i;
          CfgBucket: bkt_r = cfg_data_i[16:0];
          CfgAlign:  aln_r = cfg_data_i[7:0];
          CfgCount:  cnt_r = cfg_data_i[8:0];
          default: ;
        endcase
      end
      // compare the popped word with the oldest expectation
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          checked_o++;
          if (res_i.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, res_i.status);
            fail_count_o++;
          end
          if (res_i.first_bucket !== e.first_bucket) begin
            $error("first_bucket exp %0d got %0d", e.first_bucket, res_i.first_bucket);
            fail_count_o++;
          end
          if (res_i.block_address !== e.block_address) begin
            $error("block_address exp %h got %h", e.block_address, res_i.block_address);
            fail_count_o++;
          end
          if (res_i.usable_bytes !== e.usable_bytes) begin
            $error("usable_bytes exp %0d got %0d", e.usable_bytes, res_i.usable_bytes);
            fail_count_o++;
          end
          if (res_i.used_count !== e.used_count) begin
            $error("used_count exp %0d got %0d", e.used_count, res_i.used_count);
            fail_count_o++;
          end
        end
      end
      if (push && !full) expected_q.push_back(predict_result(req_i));
    end
  end

endmodule

>>> dv/tb_top.sv
// testbench top of the bitmap bucket allocator: stimulus and verdict
`timescale 1ns / 1ps
module tb_top;
  import bba_pkg::*;

  localparam int unsigned SettleCycles = 1000;

  typedef struct {
    logic [7:0]  first;
    logic [23:0] bytes;
  } held_blk_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  bba_req_t    req_i;
  logic        empty;
  logic        pop;
  bba_res_t    res_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  bit          steady;
  int unsigned bb_now;
  held_blk_t   live_q[$];

  bitmap_bucket_allocator uut (
    .clk_i, .rst_ni, .push, .full, .req_i, .empty, .pop, .res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  bba_checker u_checker (
    .clk_i, .rst_ni, .push, .full, .req_i, .empty, .pop, .res_i(res_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #100_000_000;
    $display("** bitmap_bucket_allocator: FAILED **");
    $finish;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side stalls
  initial begin
    int unsigned hold;
    hold = 0;
    pop = 1'b0;
    forever @(negedge clk_i) begin
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 9) < 3) hold = idle_len();
      end
    end
  end

  // remember granted blocks to free or resize later
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty && res_o.status inside {StDone, StMoved} &&
        res_o.usable_bytes != 0) begin
      live_q.push_back('{res_o.first_bucket, res_o.usable_bytes});
      if (live_q.size() > 64) void'(live_q.pop_front());
    end
  end

  task automatic send_word(bba_req_t w);
    int unsigned g;
    g = idle_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    push <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  task automatic cfg_word(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] base, logic [16:0] bkt, logic [7:0] aln,
                          logic [8:0] cnt);
    cfg_word(CfgBase, base);
    cfg_word(CfgBucket, {15'd0, bkt});
    cfg_word(CfgAlign, {24'd0, aln});
    cfg_word(CfgCount, {23'd0, cnt});
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    bb_now = (bkt == 0) ? 1 : (bkt > 17'h10000) ? 65536 : bkt;
  endtask

  function automatic bba_req_t mk(logic [1:0] op, int unsigned rq, int unsigned al,
                                  int unsigned st, int unsigned hb, bit hv);
    bba_req_t w;
    w.op = op;
    w.request_bytes = rq;
    w.align_bytes = al;
    w.held_start = st;
    w.held_bytes = hb;
    w.held_valid = hv;
    return w;
  endfunction

  // random request; frees and resizes mostly aimed at blocks granted earlier
  function automatic bba_req_t random_word();
    bba_req_t  w;
    int unsigned r, idx, top;
    held_blk_t b;
    w = {$urandom, $urandom, $urandom};
    r = $urandom_range(0, 99);
    w.op = (r < 40) ? OpAlloc : (r < 70) ? OpFree : (r < 95) ? OpResize : 2'd3;
    top = (bb_now * 6 > 24'hFFFFFF) ? 24'hFFFFFF : bb_now * 6;
    r = $urandom_range(0, 9);
    w.request_bytes = (r < 8) ? $urandom_range(1, top) :
                      (r < 9) ? $urandom_range(0, bb_now) : $urandom;
    r = $urandom_range(0, 9);
    w.align_bytes = (r < 4) ? 8'd0 : (r < 8) ? 8'(1 << $urandom_range(0, 7)) : 8'($urandom);
    if (w.op inside {OpFree, OpResize} && live_q.size() > 0 && $urandom_range(0, 99) < 85) begin
      idx = $urandom_range(0, live_q.size() - 1);
      b = live_q[idx];
      if (w.op == OpFree) live_q.delete(idx);
      w.held_start = b.first;
      w.held_bytes = $urandom_range(0, 1) ? b.bytes : 24'(bb_now * $urandom_range(1, 4));
      w.held_valid = ($urandom_range(0, 19) != 0);
    end
    return w;
  endfunction

  task automatic random_phase(int unsigned items);
    for (int unsigned i = 0; i < items; i++) send_word(random_word());
    drain();
  endtask

  // stimulus
  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    req_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgBase;
    cfg_data_i = '0;
    steady = 1'b0;
    bb_now = 64;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part at reset settings
    send_word(mk(OpAlloc, 0, 0, 0, 0, 0));          // zero request
    send_word(mk(OpAlloc, 1, 16, 0, 0, 0));
    send_word(mk(OpAlloc, 64, 32, 0, 0, 0));        // padded
    send_word(mk(OpAlloc, 65, 3, 0, 0, 0));         // non power of two align
    send_word(mk(OpAlloc, 24'hFFFFFF, 128, 0, 0, 0)); // too large
    send_word(mk(OpAlloc, 200, 128, 0, 0, 0));
    send_word(mk(OpFree, 0, 0, 0, 64, 1));
    send_word(mk(OpFree, 0, 0, 1, 64, 0));          // not owned
    send_word(mk(OpFree, 0, 0, 1, 0, 1));           // empty block
    send_word(mk(OpResize, 10, 0, 6, 384, 1));      // shrink
    send_word(mk(OpResize, 200, 0, 6, 64, 1));      // grow in place
    send_word(mk(OpResize, 1000, 0, 1, 64, 1));     // move
    send_word(mk(OpResize, 100, 0, 1, 64, 0));      // resize as allocate
    send_word(mk(2'd3, 24'hFFFFFF, 255, 255, 24'hFFFFFF, 1)); // unknown op
    send_word(mk(OpAlloc, 255, 255, 0, 0, 0));
    send_word(mk(OpResize, 1, 128, 7, 64, 1));      // in-place align past block
    send_word(mk(OpFree, 0, 0, 255, 24'hFFFFFF, 1));
    send_word(mk(OpResize, 24'hFFFFFF, 0, 2, 128, 1)); // grow that cannot fit
    drain();

    random_phase(200);
    set_regs(32'hFFFF_FF00, 17'd1, 8'd0, 9'd256);
    random_phase(190);
    set_regs($urandom, 17'h10000, 8'd128, 9'd1);
    random_phase(150);
    set_regs($urandom, 17'd100, 8'd3, 9'd300);
    random_phase(200);
    set_regs(32'd0, 17'd0, 8'd255, 9'd0);           // no buckets at all
    random_phase(60);
    set_regs(32'hFFFF_FFFF, 17'h1FFFF, 8'd8, 9'd511);
    random_phase(170);
    steady = 1'b1;
    set_regs($urandom, 17'd48, 8'd16, 9'd256);
    random_phase(180);

    $display("checked %0d result words over seven register settings", checked);
    $display("covered allocate, free, resize and unknown requests, extremes of every register");
    if (fail_count == 0) begin
      $display("** bitmap_bucket_allocator: PASSED **");
    end else begin
      $display("** bitmap_bucket_allocator: FAILED **");
    end
    $finish;
  end

endmodule
